// File: design/rwsh_pkg.sv
`default_nettype none
package rwsh_pkg;

    localparam int unsigned WordW   = 64;
    localparam int unsigned BufW    = 6;
    localparam int unsigned MinTail = 2;
    localparam int unsigned PairTail = 4;
    localparam int unsigned CntW    = 3;
    localparam int unsigned CfgIdxW = 8;

    localparam logic [CfgIdxW-1:0] REG_START_SEED  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SECRET_ZERO = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_SECRET_ONE  = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_SECRET_TWO  = 8'd3;

    localparam logic [WordW-1:0] START_SEED_RST  = 64'd13679853920966426665;
    localparam logic [WordW-1:0] SECRET_ZERO_RST = 64'd3257665815644502181;
    localparam logic [WordW-1:0] SECRET_ONE_RST  = 64'd10067880064238660809;
    localparam logic [WordW-1:0] SECRET_TWO_RST  = 64'd5418857496715711651;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FOLD,
        S_LOAD_A,
        S_LOAD_B,
        S_MUL,
        S_WAIT,
        S_POST,
        S_WRITE
    } seq_state_t;

    typedef enum logic [2:0] {
        J_OPEN,
        J_LANE_A,
        J_LANE_B,
        J_LANE_C,
        J_FIN1,
        J_FIN2,
        J_FINMUL,
        J_FINAL
    } job_t;

    typedef struct packed {
        logic             start;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [WordW-1:0] lo;
        logic [WordW-1:0] hi;
    } mul_rsp_t;

endpackage
`default_nettype wire

// File: design/rwsh_if.sv
`default_nettype none
interface rwsh_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] data_word;
    modport source (output valid, output op, output data_word, input ready);
    modport sink   (input valid, input op, input data_word, output ready);
endinterface

interface rwsh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

// File: design/rwsh_mul.sv
`default_nettype none
module rwsh_mul
    import rwsh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t  rsp
);

    logic [WordW-1:0]   a_reg;
    logic [WordW-1:0]   b_reg;
    logic [WordW-1:0]   pp_reg;
    logic [2*WordW-1:0] acc_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [31:0]        x_half;
    logic [31:0]        y_half;
    logic [1:0]         prev;
    logic [2*WordW-1:0] pp_sh;

    // partial product order: ll, lh, hl, hh
    always_comb
    begin
        x_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        y_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        prev   = 2'(cnt_reg - 3'd1);
        unique case (prev)
            2'd0:    pp_sh = {64'd0, pp_reg};
            2'd3:    pp_sh = {pp_reg, 64'd0};
            default: pp_sh = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
                pp_reg <= x_half * y_half;
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_sh;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.lo   = acc_reg[63:0];
    assign rsp.hi   = acc_reg[127:64];

endmodule
`default_nettype wire

// File: design/rapidhash_word_stream_hasher.sv
`default_nettype none
// word stream hasher: absorb transactions (op 0) buffer 64-bit words six at a
// time, a finish transaction (op 1) returns one 64-bit hash and closes the
// message; the next transaction opens a new one with seeds taken from the
// registers at that moment. all 64x64 products run on one shared multiplier
// built around a single 32x32 unit (4 partial products). an absorb does the
// seed mix when it opens a message and three lane mixes when it follows six
// buffered words; a finish does 2 mixes for up to 2 buffered words, 3 for
// 3..4, 4 for 5..6, plus the seed mix if it opens the message. one transaction
// is in work at a time; a finished hash waits in the output register while the
// next one is accepted.
// configuration may only be written while the block is idle.
module rapidhash_word_stream_hasher
    import rwsh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    rwsh_in_if.sink                 in_ch,
    rwsh_out_if.source              out_ch,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [WordW-1:0]   cfg_data
);

    seq_state_t state_reg, state_next;
    job_t       job_reg;

    // configuration
    logic [WordW-1:0] start_seed_reg;
    logic [WordW-1:0] secret_zero_reg;
    logic [WordW-1:0] secret_one_reg;
    logic [WordW-1:0] secret_two_reg;

    // message state
    logic [WordW-1:0] lane_a_reg;
    logic [WordW-1:0] lane_b_reg;
    logic [WordW-1:0] lane_c_reg;
    logic [WordW-1:0] seed_reg;
    logic [WordW-1:0] prod_lo_reg;
    logic [WordW-1:0] prod_hi_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             open_reg;

    // current transaction
    logic             op_reg;
    logic [WordW-1:0] word_reg;

    // word buffer, registered read
    logic [WordW-1:0] buf_mem [BufW];
    logic [WordW-1:0] rd_reg;
    logic             rd_zero_reg;
    logic [WordW-1:0] opa_reg;

    // output register
    logic [WordW-1:0] hash_reg;
    logic             out_valid_reg;

    logic             in_fire;
    logic             out_fire;
    logic [CntW-1:0]  addr;
    logic [CntW-1:0]  idx_a;
    logic [CntW-1:0]  idx_b;
    logic [CntW-1:0]  tail_n;
    logic             use_buf;
    logic [WordW-1:0] xa;
    logic [WordW-1:0] xb;
    logic [WordW-1:0] rd_eff;
    logic [WordW-1:0] mix_val;
    logic             final_go;
    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.hash_value = hash_reg;

    assign rd_eff   = rd_zero_reg ? '0 : rd_reg;
    assign mix_val  = mul_rsp.lo ^ mul_rsp.hi;
    assign final_go = !out_valid_reg || out_ch.ready;
    // short message pads up to two words
    assign tail_n   = (cnt_reg < CntW'(MinTail)) ? CntW'(MinTail) : cnt_reg;

    // operand sources of each mix job
    always_comb
    begin
        use_buf = 1'b1;
        idx_a   = '0;
        idx_b   = '0;
        xa      = '0;
        xb      = '0;
        unique case (job_reg)
            J_OPEN:
            begin
                use_buf = 1'b0;
                xa      = start_seed_reg ^ secret_zero_reg;
                xb      = secret_one_reg;
            end
            J_LANE_A:
            begin
                idx_a = 3'd0;
                idx_b = 3'd1;
                xa    = secret_zero_reg;
                xb    = lane_a_reg;
            end
            J_LANE_B:
            begin
                idx_a = 3'd2;
                idx_b = 3'd3;
                xa    = secret_one_reg;
                xb    = lane_b_reg;
            end
            J_LANE_C:
            begin
                idx_a = 3'd4;
                idx_b = 3'd5;
                xa    = secret_two_reg;
                xb    = lane_c_reg;
            end
            J_FIN1:
            begin
                idx_a = 3'd0;
                idx_b = 3'd1;
                xa    = secret_two_reg;
                xb    = seed_reg ^ secret_one_reg;
            end
            J_FIN2:
            begin
                idx_a = 3'd2;
                idx_b = 3'd3;
                xa    = secret_two_reg;
                xb    = seed_reg;
            end
            J_FINMUL:
            begin
                idx_a = tail_n - 3'd2;
                idx_b = tail_n - 3'd1;
                xa    = secret_one_reg;
                xb    = seed_reg;
            end
            J_FINAL:
            begin
                use_buf = 1'b0;
                xa      = prod_lo_reg ^ secret_zero_reg;
                xb      = prod_hi_reg ^ secret_one_reg;
            end
            default:
            begin
                use_buf = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = open_reg ? S_DISPATCH : S_LOAD_A;
            S_DISPATCH:
                if (op_reg == OP_FINISH)
                    state_next = S_FOLD;
                else if (cnt_reg == CntW'(BufW))
                    state_next = S_LOAD_A;
                else
                    state_next = S_WRITE;
            S_FOLD:   state_next = S_LOAD_A;
            S_LOAD_A: state_next = S_LOAD_B;
            S_LOAD_B: state_next = S_MUL;
            S_MUL:    state_next = S_WAIT;
            S_WAIT:
                if (mul_rsp.done)
                    state_next = S_POST;
            S_POST:
                unique case (job_reg)
                    J_OPEN:   state_next = S_DISPATCH;
                    J_LANE_C: state_next = S_WRITE;
                    J_FINAL:  state_next = final_go ? S_IDLE : S_POST;
                    default:  state_next = S_LOAD_A;
                endcase
            S_WRITE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // buffer address and multiplier request
    always_comb
    begin
        addr          = (state_reg == S_LOAD_B) ? idx_b : idx_a;
        mul_req.start = (state_reg == S_MUL);
        mul_req.a     = opa_reg;
        mul_req.b     = rd_eff ^ xb;
    end

    rwsh_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            job_reg         <= J_OPEN;
            cnt_reg         <= '0;
            open_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            start_seed_reg  <= START_SEED_RST;
            secret_zero_reg <= SECRET_ZERO_RST;
            secret_one_reg  <= SECRET_ONE_RST;
            secret_two_reg  <= SECRET_TWO_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_SEED:  start_seed_reg  <= cfg_data;
                    REG_SECRET_ZERO: secret_zero_reg <= cfg_data;
                    REG_SECRET_ONE:  secret_one_reg  <= cfg_data;
                    REG_SECRET_TWO:  secret_two_reg  <= cfg_data;
                    default:         ;
                endcase
            end

            // a new hash may load in the same cycle the old one leaves
            if (state_reg == S_POST && job_reg == J_FINAL && final_go)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (in_fire && !open_reg)
                        job_reg <= J_OPEN;
                S_DISPATCH:
                    if (op_reg == OP_ABSORB && cnt_reg == CntW'(BufW))
                        job_reg <= J_LANE_A;
                S_FOLD:
                    job_reg <= (cnt_reg > CntW'(MinTail)) ? J_FIN1 : J_FINMUL;
                S_POST:
                    unique case (job_reg)
                        J_OPEN:
                        begin
                            cnt_reg  <= '0;
                            open_reg <= 1'b1;
                        end
                        J_LANE_A: job_reg <= J_LANE_B;
                        J_LANE_B: job_reg <= J_LANE_C;
                        J_LANE_C: cnt_reg <= '0;
                        J_FIN1:
                            job_reg <= (cnt_reg > CntW'(PairTail)) ? J_FIN2 : J_FINMUL;
                        J_FIN2:   job_reg <= J_FINMUL;
                        J_FINMUL: job_reg <= J_FINAL;
                        J_FINAL:
                            if (final_go)
                            begin
                                cnt_reg  <= '0;
                                open_reg <= 1'b0;
                            end
                        default: ;
                    endcase
                S_WRITE:
                    cnt_reg <= cnt_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= in_ch.op;
            word_reg <= in_ch.data_word;
        end

        // unfilled slots past the count read as zero pad words
        rd_reg      <= buf_mem[addr];
        rd_zero_reg <= !use_buf || (addr >= cnt_reg);

        if (state_reg == S_LOAD_B)
            opa_reg <= rd_eff ^ xa;

        if (state_reg == S_WRITE)
            buf_mem[cnt_reg] <= word_reg;

        if (state_reg == S_FOLD)
            seed_reg <= lane_a_reg ^ lane_b_reg ^ lane_c_reg;

        if (state_reg == S_POST)
        begin
            unique case (job_reg)
                J_OPEN:
                begin
                    lane_a_reg <= start_seed_reg ^ mix_val;
                    lane_b_reg <= start_seed_reg ^ mix_val;
                    lane_c_reg <= start_seed_reg ^ mix_val;
                end
                J_LANE_A: lane_a_reg <= mix_val;
                J_LANE_B: lane_b_reg <= mix_val;
                J_LANE_C: lane_c_reg <= mix_val;
                J_FIN1:   seed_reg   <= mix_val;
                J_FIN2:   seed_reg   <= mix_val;
                J_FINMUL:
                begin
                    prod_lo_reg <= mul_rsp.lo;
                    prod_hi_reg <= mul_rsp.hi;
                end
                J_FINAL:
                    if (final_go)
                        hash_reg <= mix_val;
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_WAIT))
        else $error("multiplier done outside wait");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(BufW))
        else $error("buffer count overflow");

    a_open_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !open_reg) |=> (state_reg == S_LOAD_A && job_reg == J_OPEN))
        else $error("message open not started");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (cnt_reg < CntW'(BufW)))
        else $error("write into full buffer");
`endif

endmodule
`default_nettype wire
